// ===== src/ptcs_pkg.sv =====
// Shared types and constants for the POV text column sequencer.
// No dependencies; used by ptcs_regs, the sequencer and the checker.
`default_nettype none

package ptcs_pkg;

    // Store geometry
    localparam int TEXT_DEPTH   = 256;
    localparam int TEXT_AW      = $clog2(TEXT_DEPTH);
    localparam int GLYPH_COUNT  = 64;
    localparam int GLYPH_W      = $clog2(GLYPH_COUNT);
    localparam int FONT_STRIDE  = 8;
    localparam int STRIDE_W     = $clog2(FONT_STRIDE);
    localparam int FONT_DEPTH   = GLYPH_COUNT * FONT_STRIDE;
    localparam int FONT_AW      = $clog2(FONT_DEPTH);
    localparam int MAX_COLUMNS  = 8;

    localparam logic [15:0] SEQUENCE_MIN_TICKS = 16'd50;
    localparam logic [8:0]  TEXT_LEN_MAX       = 9'd255;

    // Character handling
    localparam logic [7:0] GLYPH_BASE_CHAR = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_OFFSET     = 8'd32;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Config port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_FONT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_WINDOW_BEGIN  = 3'd0,
        REG_WINDOW_END    = 3'd1,
        REG_GAP_TICKS     = 3'd2,
        REG_SCROLL_PERIOD = 3'd3,
        REG_SCROLL_STEP   = 3'd4,
        REG_GLYPH_WIDTH   = 3'd5,
        REG_SPACING       = 3'd6,
        REG_REPEAT_TEXT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] window_begin;
        logic [15:0] window_end;
        logic [7:0]  gap_ticks;
        logic [15:0] scroll_period;
        logic [3:0]  scroll_step;
        logic [3:0]  glyph_width;
        logic [7:0]  spacing_columns;
        logic        repeat_text;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        window_begin:    16'd110,
        window_end:      16'd330,
        gap_ticks:       8'd1,
        scroll_period:   16'd200,
        scroll_step:     4'd2,
        glyph_width:     4'd5,
        spacing_columns: 8'd1,
        repeat_text:     1'b1
    };

endpackage

`default_nettype wire

// ===== src/ptcs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ptcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/ptcs_regs.sv =====
// APB-style configuration register file for the POV text column sequencer.
// Depends on ptcs_pkg.
`default_nettype none

module ptcs_regs
    import ptcs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_WINDOW_BEGIN:  cfg_reg.window_begin    <= pwdata[15:0];
                REG_WINDOW_END:    cfg_reg.window_end      <= pwdata[15:0];
                REG_GAP_TICKS:     cfg_reg.gap_ticks       <= pwdata[7:0];
                REG_SCROLL_PERIOD: cfg_reg.scroll_period   <= pwdata[15:0];
                REG_SCROLL_STEP:   cfg_reg.scroll_step     <= pwdata[3:0];
                REG_GLYPH_WIDTH:   cfg_reg.glyph_width     <= pwdata[3:0];
                REG_SPACING:       cfg_reg.spacing_columns <= pwdata[7:0];
                REG_REPEAT_TEXT:   cfg_reg.repeat_text     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WINDOW_BEGIN:  prdata = {16'd0, cfg_reg.window_begin};
            REG_WINDOW_END:    prdata = {16'd0, cfg_reg.window_end};
            REG_GAP_TICKS:     prdata = {24'd0, cfg_reg.gap_ticks};
            REG_SCROLL_PERIOD: prdata = {16'd0, cfg_reg.scroll_period};
            REG_SCROLL_STEP:   prdata = {28'd0, cfg_reg.scroll_step};
            REG_GLYPH_WIDTH:   prdata = {28'd0, cfg_reg.glyph_width};
            REG_SPACING:       prdata = {24'd0, cfg_reg.spacing_columns};
            REG_REPEAT_TEXT:   prdata = {31'd0, cfg_reg.repeat_text};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/pov_text_column_sequencer.sv =====
// Tick path: ST_SCROLL when a scroll step fires and the glyph width is nonzero, then ST_DECIDE;
// ST_TEXT and ST_FONT follow when a font column is read (text then font memory read), ST_TEXT
// alone for a blank character, neither when no column is read; ST_DONE registers the result.
// s_tready is low from a tick until the result is registered; write and begin stay in ST_IDLE.
// Reset: synchronous, active low; counters and positions clear, text length is 1.
// Text and font memories are not cleared and read as garbage until written.
`default_nettype none

module pov_text_column_sequencer
    import ptcs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // slave stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // address[8:0], data[16:9], zero pad
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // command[1:0]
    input  wire logic                 s_tlast,  // last_char
    // master stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // led_value[7:0], in_window[8], zero pad
    // config port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [CFG_DW-1:0]    pwdata,
    output logic      [CFG_DW-1:0]    prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_DECIDE,
        ST_TEXT,
        ST_FONT,
        ST_DONE
    } state_t;

    cfg_t   cfg;
    state_t state_reg;

    logic [15:0] tick_count_reg;
    logic [7:0]  gap_count_reg;
    logic [7:0]  space_count_reg;
    logic [15:0] scroll_count_reg;
    logic [7:0]  char_pos_reg;
    logic [7:0]  column_pos_reg;
    logic [7:0]  start_char_reg;
    logic [7:0]  start_column_reg;
    logic [7:0]  port_value_reg;
    logic [8:0]  text_length_reg;
    logic [STRIDE_W-1:0] col_sel_reg;
    logic        inside_reg;
    logic        m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // request fields
    logic [8:0] in_address;
    logic [7:0] in_data;
    cmd_t       in_cmd;
    logic       in_accept;

    assign in_address = s_tdata[8:0];
    assign in_data    = s_tdata[16:9];
    assign in_cmd     = cmd_t'(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;

    // memories
    logic                 text_we;
    logic [7:0]           text_rdata;
    logic                 font_we;
    logic [FONT_AW-1:0]   font_raddr;
    logic [7:0]           font_rdata;

    assign text_we = in_accept && (in_cmd == CMD_TEXT) && (in_address < 9'(TEXT_DEPTH));
    assign font_we = in_accept && (in_cmd == CMD_FONT);

    ptcs_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_ram (
        .aclk  (aclk),
        .we    (text_we),
        .waddr (in_address[TEXT_AW-1:0]),
        .wdata (in_data),
        .raddr (char_pos_reg[TEXT_AW-1:0]),
        .rdata (text_rdata)
    );

    ptcs_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font_ram (
        .aclk  (aclk),
        .we    (font_we),
        .waddr (in_address[FONT_AW-1:0]),
        .wdata (in_data),
        .raddr (font_raddr),
        .rdata (font_rdata)
    );

    ptcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // character fold and glyph lookup on text read data
    logic [7:0] char_folded;
    logic [7:0] glyph_index;
    logic       char_shown;

    always_comb begin
        char_folded = text_rdata;
        if (text_rdata >= CHAR_LOWER_A && text_rdata <= CHAR_LOWER_Z) begin
            char_folded = text_rdata - CASE_OFFSET;
        end
        char_shown  = (char_folded >= GLYPH_BASE_CHAR) && (char_folded <= CHAR_UNDERSCORE);
        glyph_index = char_folded - GLYPH_BASE_CHAR;
        font_raddr  = {glyph_index[GLYPH_W-1:0], col_sel_reg};
    end

    // shared helpers
    logic [8:0]  text_last;
    logic [9:0]  len_sum;
    logic [7:0]  glyph_w8;
    logic        win_hit;
    logic        out_free;
    logic        scroll_fire;
    logic        col_emit;
    logic        col_fetch;

    assign text_last = text_length_reg - 9'd1;
    assign len_sum   = {1'b0, in_address} + 10'd1;
    assign glyph_w8  = {4'd0, cfg.glyph_width};
    assign win_hit   = (tick_count_reg >= cfg.window_begin) &&
                       (tick_count_reg <= cfg.window_end);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign scroll_fire = (cfg.scroll_period != 16'd0) &&
                         (scroll_count_reg > cfg.scroll_period);
    // a column slot is used this tick; fetch when it maps to a stored glyph column
    assign col_emit  = win_hit && (gap_count_reg > cfg.gap_ticks) &&
                       (space_count_reg > cfg.spacing_columns) &&
                       (column_pos_reg < glyph_w8);
    assign col_fetch = col_emit && ({1'b0, char_pos_reg} < text_length_reg) &&
                       (column_pos_reg < 8'(MAX_COLUMNS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tick_count_reg   <= '0;
            gap_count_reg    <= '0;
            space_count_reg  <= '0;
            scroll_count_reg <= '0;
            char_pos_reg     <= '0;
            column_pos_reg   <= '0;
            start_char_reg   <= '0;
            start_column_reg <= '0;
            port_value_reg   <= '0;
            text_length_reg  <= 9'd1;
            inside_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !(state_reg == ST_DONE && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        case (in_cmd)
                            CMD_TICK: begin
                                state_reg <= (scroll_fire && cfg.glyph_width != 4'd0) ?
                                             ST_SCROLL : ST_DECIDE;
                                if (cfg.scroll_period != 16'd0) begin
                                    if (scroll_count_reg > cfg.scroll_period) begin
                                        scroll_count_reg <= '0;
                                        start_column_reg <= start_column_reg +
                                                            {4'd0, cfg.scroll_step};
                                        column_pos_reg   <= column_pos_reg + 8'd1;
                                    end else begin
                                        scroll_count_reg <= scroll_count_reg + 16'd1;
                                    end
                                end
                            end
                            CMD_BEGIN: begin
                                if (tick_count_reg >= SEQUENCE_MIN_TICKS) begin
                                    tick_count_reg  <= '0;
                                    gap_count_reg   <= cfg.gap_ticks;
                                    space_count_reg <= cfg.spacing_columns;
                                    char_pos_reg    <= start_char_reg;
                                    column_pos_reg  <= start_column_reg;
                                end
                            end
                            CMD_TEXT: begin
                                if (text_we && s_tlast) begin
                                    text_length_reg  <= (len_sum > {1'b0, TEXT_LEN_MAX}) ?
                                                        TEXT_LEN_MAX : len_sum[8:0];
                                    start_char_reg   <= '0;
                                    start_column_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // one glyph-width subtraction per cycle
                ST_SCROLL: begin
                    if (start_column_reg >= glyph_w8) begin
                        start_column_reg <= start_column_reg - glyph_w8;
                        if ({1'b0, start_char_reg} >= text_last) begin
                            start_char_reg <= '0;
                        end else begin
                            start_char_reg <= start_char_reg + 8'd1;
                        end
                    end else begin
                        state_reg <= ST_DECIDE;
                    end
                end

                ST_DECIDE: begin
                    inside_reg     <= win_hit;
                    tick_count_reg <= tick_count_reg + 16'd1;
                    gap_count_reg  <= col_emit ? 8'd1 : gap_count_reg + 8'd1;
                    // text read at char_pos is issued this cycle
                    state_reg      <= col_fetch ? ST_TEXT : ST_DONE;
                    if (!win_hit) begin
                        port_value_reg <= '0;
                    end else if (gap_count_reg > cfg.gap_ticks) begin
                        port_value_reg <= '0;
                        if (space_count_reg > cfg.spacing_columns) begin
                            if (column_pos_reg < glyph_w8) begin
                                col_sel_reg    <= column_pos_reg[STRIDE_W-1:0];
                                column_pos_reg <= column_pos_reg + 8'd1;
                            end else begin
                                column_pos_reg  <= '0;
                                space_count_reg <= '0;
                                if ({1'b0, char_pos_reg} >= text_last) begin
                                    char_pos_reg <= cfg.repeat_text ? 8'd0 :
                                                    text_length_reg[7:0];
                                end else begin
                                    char_pos_reg <= char_pos_reg + 8'd1;
                                end
                            end
                        end else begin
                            space_count_reg <= space_count_reg + 8'd1;
                        end
                    end
                end

                ST_TEXT: begin
                    state_reg <= char_shown ? ST_FONT : ST_DONE;
                end

                ST_FONT: begin
                    port_value_reg <= font_rdata;
                    state_reg      <= ST_DONE;
                end

                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, inside_reg, port_value_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== src/ptcs_checker.sv =====
// Port-level assertions for pov_text_column_sequencer, attached by bind.
// Depends on ptcs_pkg.
`default_nettype none

module ptcs_checker
    import ptcs_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // outside the window the column is dark
    a_dark_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("lit column outside display window");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:9] == '0)
        else $error("padding bits set in result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind pov_text_column_sequencer ptcs_checker u_ptcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
